>>> hdl/trajectory_speed_score_assert.svh
// Assertion macros shared by the trajectory speed score checker.
// No dependencies.
`ifndef TRAJECTORY_SPEED_SCORE_ASSERT_SVH
`define TRAJECTORY_SPEED_SCORE_ASSERT_SVH

// Assert a property that is checked outside reset.
`define TSS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Assert that a stalled signal holds its value.
`define TSS_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> $stable(sig)) else $error("stalled value changed");

`endif

>>> hdl/tss_pkg.sv
// Shared types and constants for the trajectory speed score block.
// No dependencies.
package tss_pkg;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusLinUnset = 2'd1,
    StatusAngUnset = 2'd2,
    StatusTimeUnset = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegMaxLin  = 2'd0,
    RegMaxTurn = 2'd1,
    RegSpan    = 2'd2
  } reg_idx_e;

  // Request passed from the front to the back through the queue.
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [32:0] dh;
    logic        step;
    logic        last;
  } work_t;

  typedef enum logic [2:0] {
    BkIdle  = 3'd0,
    BkMul   = 3'd1,
    BkSqrt  = 3'd2,
    BkAcc   = 3'd3,
    BkDivL  = 3'd4,
    BkDivA  = 3'd5,
    BkOut   = 3'd6
  } back_state_e;

  localparam logic [31:0] ScoreOne = 32'h0001_0000;

endpackage

>>> hdl/tss_front.sv
// Front part: accepts points, keeps the previous point, forms absolute deltas.
// Depends on tss_pkg.
module tss_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          pos_x_i,
  input  logic [31:0]          pos_y_i,
  input  logic [31:0]          heading_i,
  input  logic                 last_point_i,
  output logic                 push_o,
  output tss_pkg::work_t       push_data_o,
  input  logic                 full_i
);
  logic [31:0] prev_x_q, prev_y_q, prev_h_q;
  logic        first_q;
  logic signed [32:0] dx, dy, dh;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    dx = {pos_x_i[31], pos_x_i} - {prev_x_q[31], prev_x_q};
    dy = {pos_y_i[31], pos_y_i} - {prev_y_q[31], prev_y_q};
    dh = {heading_i[31], heading_i} - {prev_h_q[31], prev_h_q};
    push_data_o.ax   = dx[32] ? 32'(-dx) : dx[31:0];
    push_data_o.ay   = dy[32] ? 32'(-dy) : dy[31:0];
    push_data_o.dh   = dh[32] ? 33'(-dh) : 33'(dh);
    push_data_o.step = !first_q;
    push_data_o.last = last_point_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_h_q <= '0;
      first_q  <= 1'b1;
    end else if (push_o) begin
      prev_x_q <= pos_x_i;
      prev_y_q <= pos_y_i;
      prev_h_q <= heading_i;
      first_q  <= last_point_i;
    end
  end
endmodule

>>> hdl/tss_queue.sv
// Two-entry queue between the front and back parts.
// Depends on tss_pkg.
module tss_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tss_pkg::work_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tss_pkg::work_t pop_data_o
);
  tss_pkg::work_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

>>> hdl/tss_back.sv
// Back part: squares, root, saturating sums and the final score divisions.
// Depends on tss_pkg.
module tss_back #(
  parameter int unsigned SumWidth = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tss_pkg::work_t pop_data_i,
  output logic           pop_o,
  input  logic [31:0]    max_lin_i,
  input  logic [31:0]    max_turn_i,
  input  logic [31:0]    span_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    score_o,
  output logic [1:0]     status_o
);
  localparam int unsigned NumW = SumWidth + 32;
  localparam logic [SumWidth-1:0] SumMax = '1;

  tss_pkg::back_state_e state_q, state_d;
  tss_pkg::work_t       item_q;
  logic [63:0]          sq_x_q, sq_y_q;
  logic [64:0]          rad_q;
  logic [32:0]          root_q;
  logic [34:0]          rem_q;
  logic [6:0]           cnt_q;
  logic [SumWidth-1:0]  len_q, turn_q;
  logic [NumW-1:0]      num_q, quo_q;
  logic [64:0]          drem_q;
  logic [63:0]          div_q;
  logic [NumW-1:0]      lin_q;
  logic [31:0]          score_q;
  logic [1:0]           status_q;
  logic                 out_valid_q;

  // root step
  logic [34:0] rem_sh, trial;
  logic [SumWidth:0] len_add, turn_add;
  logic [64:0] drem_sh;
  logic [NumW+1:0] fin;
  logic [1:0]      stat;

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign status_o    = status_q;
  assign pop_o       = state_q == tss_pkg::BkIdle && !empty_i && !out_valid_q;

  always_comb begin
    rem_sh   = {rem_q[32:0], rad_q[64:63]};
    trial    = {root_q[32:0], 2'b01};
    len_add  = {1'b0, len_q} + (SumWidth+1)'(root_q);
    turn_add = {1'b0, turn_q} + (SumWidth+1)'(item_q.dh);
    drem_sh  = {drem_q[63:0], num_q[NumW-1]};
    fin      = (NumW+2)'(quo_q) + (NumW+2)'(tss_pkg::ScoreOne) - (NumW+2)'(lin_q);
    if (max_lin_i == '0)       stat = tss_pkg::StatusLinUnset;
    else if (max_turn_i == '0) stat = tss_pkg::StatusAngUnset;
    else if (span_i == '0)     stat = tss_pkg::StatusTimeUnset;
    else                       stat = tss_pkg::StatusOk;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tss_pkg::BkIdle: if (pop_o) state_d = tss_pkg::BkMul;
      tss_pkg::BkMul:  state_d = tss_pkg::BkSqrt;
      tss_pkg::BkSqrt: if (cnt_q == 7'd0) state_d = tss_pkg::BkAcc;
      tss_pkg::BkAcc: begin
        if (!item_q.last) state_d = tss_pkg::BkIdle;
        else if (stat != tss_pkg::StatusOk) state_d = tss_pkg::BkOut;
        else state_d = tss_pkg::BkDivL;
      end
      tss_pkg::BkDivL: if (cnt_q == 7'd0) state_d = tss_pkg::BkDivA;
      tss_pkg::BkDivA: if (cnt_q == 7'd0) state_d = tss_pkg::BkOut;
      tss_pkg::BkOut:  state_d = tss_pkg::BkIdle;
      default:         state_d = tss_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tss_pkg::BkIdle;
      item_q      <= '0;
      sq_x_q      <= '0;
      sq_y_q      <= '0;
      rad_q       <= '0;
      root_q      <= '0;
      rem_q       <= '0;
      len_q       <= '0;
      turn_q      <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      drem_q      <= '0;
      div_q       <= '0;
      lin_q       <= '0;
      score_q     <= '0;
      status_q    <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        tss_pkg::BkIdle: if (pop_o) item_q <= pop_data_i;
        tss_pkg::BkMul: begin
          sq_x_q <= 64'(item_q.ax) * 64'(item_q.ax);
          sq_y_q <= 64'(item_q.ay) * 64'(item_q.ay);
          cnt_q  <= 7'd33;
          root_q <= '0;
          rem_q  <= '0;
        end
        tss_pkg::BkSqrt: begin
          if (cnt_q == 7'd33) begin
            // top pair is the lone carry bit; its trial leaves no remainder
            rad_q  <= ({1'b0, sq_x_q} + {1'b0, sq_y_q}) << 1;
            rem_q  <= '0;
            root_q <= 33'(({1'b0, sq_x_q} + {1'b0, sq_y_q}) >> 64);
          end else if (cnt_q != 7'd0) begin
            rad_q <= rad_q << 2;
            if (rem_sh >= trial) begin
              rem_q  <= rem_sh - trial;
              root_q <= {root_q[31:0], 1'b1};
            end else begin
              rem_q  <= rem_sh;
              root_q <= {root_q[31:0], 1'b0};
            end
          end
          cnt_q <= cnt_q - 7'd1;
        end
        tss_pkg::BkAcc: begin
          if (item_q.step) begin
            len_q  <= len_add[SumWidth] ? SumMax : len_add[SumWidth-1:0];
            turn_q <= turn_add[SumWidth] ? SumMax : turn_add[SumWidth-1:0];
            num_q  <= {(len_add[SumWidth] ? SumMax : len_add[SumWidth-1:0]), 32'd0};
          end else begin
            num_q <= {len_q, 32'd0};
          end
          div_q  <= 64'(span_i) * 64'(max_lin_i);
          drem_q <= '0;
          quo_q  <= '0;
          cnt_q  <= 7'(NumW - 1);
        end
        tss_pkg::BkDivL, tss_pkg::BkDivA: begin
          if (cnt_q == 7'd0 && state_q == tss_pkg::BkDivL) begin
            lin_q  <= (drem_sh >= {1'b0, div_q}) ? {quo_q[NumW-2:0], 1'b1}
                                                 : {quo_q[NumW-2:0], 1'b0};
            num_q  <= {turn_q, 32'd0};
            div_q  <= 64'(span_i) * 64'(max_turn_i);
            drem_q <= '0;
            quo_q  <= '0;
            cnt_q  <= 7'(NumW - 1);
          end else begin
            num_q <= num_q << 1;
            if (drem_sh >= {1'b0, div_q}) begin
              drem_q <= drem_sh - {1'b0, div_q};
              quo_q  <= {quo_q[NumW-2:0], 1'b1};
            end else begin
              drem_q <= drem_sh;
              quo_q  <= {quo_q[NumW-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 7'd1;
          end
        end
        tss_pkg::BkOut: begin
          out_valid_q <= 1'b1;
          status_q    <= stat;
          if (stat != tss_pkg::StatusOk) score_q <= '0;
          else if (fin[NumW+1]) score_q <= '0;
          else if (fin[NumW:32] != '0) score_q <= '1;
          else score_q <= fin[31:0];
          len_q  <= '0;
          turn_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/trajectory_speed_score.sv
// Top level of the trajectory speed score block: registers, front, queue, back.
// Depends on tss_pkg, tss_front, tss_queue, tss_back.
//
// Usage: points enter on in_valid_i/in_ready_o, last_point_i marks the end of
// a trajectory. Only a request with last_point_i set produces a result on
// out_valid_o/out_ready_i: score_o (Q16.16) and status_o. Registers are
// written on cfg_valid_i/cfg_ready_o (always ready) at cfg_index_i.
// Each point passes through the back part's bit-per-cycle square root over
// the 65-bit radicand. A last point with all registers set adds two
// restoring divisions of a SumWidth+32-bit numerator. The front accepts a point
// per cycle until the two-entry queue fills. Reset clears registers, sums and
// the previous point. A stalled receiver holds the result; the back part
// stops taking queue entries while a result waits, so the input then stalls
// once the queue is full.
module trajectory_speed_score #(
  parameter int unsigned SUM_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] heading_i,
  input  logic        last_point_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] score_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [31:0] max_lin_q, max_turn_q, span_q;
  logic push, full, pop, empty;
  tss_pkg::work_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q  <= '0;
      max_turn_q <= '0;
      span_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tss_pkg::RegMaxLin:  max_lin_q  <= cfg_data_i;
        tss_pkg::RegMaxTurn: max_turn_q <= cfg_data_i;
        tss_pkg::RegSpan:    span_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tss_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .pos_x_i, .pos_y_i, .heading_i, .last_point_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  tss_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  tss_back #(.SumWidth(SUM_WIDTH)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .pop_data_i(pop_data), .pop_o(pop),
    .max_lin_i(max_lin_q), .max_turn_i(max_turn_q), .span_i(span_q),
    .out_valid_o, .out_ready_i, .score_o, .status_o
  );
endmodule

>>> hdl/tss_checker.sv
// Port-level checker for the trajectory speed score block, with its bind.
// Depends on trajectory_speed_score_assert.svh and tss_pkg.
`include "trajectory_speed_score_assert.svh"
module tss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] score_o,
  input logic [1:0]  status_o,
  input logic        cfg_ready_o
);
  `TSS_ASSERT_HOLD(a_score_hold, clk_i, rst_ni, out_valid_o, out_ready_i, score_o)
  `TSS_ASSERT(a_unset_zero, clk_i, rst_ni, (out_valid_o && status_o != tss_pkg::StatusOk) |-> score_o == '0)
  `TSS_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
  `TSS_ASSERT(a_one_result, clk_i, rst_ni, (out_valid_o && out_ready_i) |=> !out_valid_o)
endmodule

bind trajectory_speed_score tss_checker u_tss_checker (.*);

>>> bench/trajectory_speed_score_tb.sv
// Self-checking bench for trajectory_speed_score: streams trajectories and checks score/status.
// Depends on tss_pkg and the trajectory_speed_score RTL; no other files.
module trajectory_speed_score_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SumW = 48;
  localparam logic [1:0] RegUnused = 2'd3;  // index outside the register map
  localparam int unsigned DrainCycles = 400;

  typedef struct {
    logic [31:0]      score;
    tss_pkg::status_e status;
  } score_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, heading_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] score_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  trajectory_speed_score #(.SUM_WIDTH(SumW)) u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block's registers and trajectory state
  logic [31:0] lin_max, turn_max, span;
  logic [31:0] last_x, last_y, last_h;
  logic first_pt;
  logic [SumW-1:0] len_acc, turn_acc;
  score_t scores_due[$];
  int errors = 0, points_sent = 0, scores_seen = 0, trajs_sent = 0;

  function automatic logic [32:0] abs_delta(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [32:0] floor_sqrt(logic [64:0] rad);
    logic [65:0] padded;
    logic [67:0] rem, trial;
    logic [32:0] root;
    padded = {1'b0, rad};
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | padded[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[31:0], 1'b1};
      end else begin
        root = {root[31:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic logic [SumW-1:0] sat_sum(logic [SumW-1:0] a, logic [32:0] b);
    logic [SumW:0] s;
    s = a + b;
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  function automatic logic [127:0] rate_of(logic [SumW-1:0] acc, logic [31:0] lim);
    logic [127:0] num, den;
    num = 128'(acc) << 32;
    den = 128'(64'(span) * 64'(lim));
    return num / den;
  endfunction

  function automatic logic [31:0] score_of();
    logic [127:0] lin, ang;
    lin = rate_of(len_acc, lin_max);
    ang = rate_of(turn_acc, turn_max) + 128'h1_0000;
    if (lin > ang) return '0;
    if (ang - lin > 128'hFFFF_FFFF) return '1;
    return 32'(ang - lin);
  endfunction

  task automatic predict_point(logic [31:0] x, logic [31:0] y, logic [31:0] h, logic last);
    logic [32:0] dx, dy;
    score_t r;
    if (first_pt) begin
      first_pt = 1'b0;
    end else begin
      dx = abs_delta(x, last_x);
      dy = abs_delta(y, last_y);
      len_acc = sat_sum(len_acc, floor_sqrt(65'(64'(dx) * 64'(dx)) + 65'(64'(dy) * 64'(dy))));
      turn_acc = sat_sum(turn_acc, abs_delta(h, last_h));
    end
    last_x = x;
    last_y = y;
    last_h = h;
    if (last) begin
      r.score = '0;
      if (lin_max == 0) r.status = tss_pkg::StatusLinUnset;
      else if (turn_max == 0) r.status = tss_pkg::StatusAngUnset;
      else if (span == 0) r.status = tss_pkg::StatusTimeUnset;
      else begin
        r.status = tss_pkg::StatusOk;
        r.score = score_of();
      end
      scores_due.push_back(r);
      len_acc = '0;
      turn_acc = '0;
      first_pt = 1'b1;
      trajs_sent++;
    end
  endtask

  // Sender bursts: gaps only between requests, valid held through a stall
  int burst_left = 0;
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] h, logic last);
    logic acc;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    heading_i <= h;
    last_point_i <= last;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
    end while (!acc);
    predict_point(x, y, h, last);
    points_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scores_due.size() != 0) @(posedge clk_i);
    // non-final points may still be in the back part
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    case (idx)
      tss_pkg::RegMaxLin: lin_max = val;
      tss_pkg::RegMaxTurn: turn_max = val;
      tss_pkg::RegSpan: span = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [31:0] lin, logic [31:0] turn, logic [31:0] t);
    wait_idle();
    write_reg(tss_pkg::RegMaxLin, lin);
    write_reg(tss_pkg::RegMaxTurn, turn);
    write_reg(tss_pkg::RegSpan, t);
  endtask

  // Receiver: random stall runs, with stretches that never stall
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(negedge clk_i) begin
    score_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      scores_seen++;
      if (scores_due.size() == 0) begin
        $display("%t: unexpected result score=%h status=%0d", $realtime, score_o, status_o);
        errors++;
      end else begin
        e = scores_due.pop_front();
        if (score_o !== e.score) begin
          $display("%t: score mismatch expected %h actual %h", $realtime, e.score, score_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $display("%t: status mismatch expected %0d actual %0d", $realtime, e.status,
                   status_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_limit();
    case ($urandom_range(0, 5))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  task automatic test_unset();
    // reset leaves all three unset; then set them one at a time, and finally clear only the linear limit
    send_point(32'd5, 32'd5, 32'd5, 1'b1);
    set_limits(32'h1_0000, 32'd0, 32'd0);
    send_point(32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'h1_0000, 32'd0, 32'd0, 1'b1);
    set_limits(32'h1_0000, 32'h1_0000, 32'd0);
    send_point(32'd0, 32'd0, 32'd0, 1'b1);
    set_limits(32'd0, 32'h1_0000, 32'h1_0000);
    send_point(32'd0, 32'd0, 32'd0, 1'b1);
  endtask

  task automatic test_single_point();
    set_limits(32'h2_0000, 32'h1_0000, 32'h1_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1);
    send_point(32'd0, 32'd0, 32'd0, 1'b1);
  endtask

  task automatic test_extremes();
    // out-of-range index must leave registers alone, though all three are rewritten next
    wait_idle();
    write_reg(RegUnused, 32'hDEAD_BEEF);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // largest deltas push the squared distance past 64 bits
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_point(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
  endtask

  task automatic test_score_bounds();
    // tiny limits: turn term saturates the score high
    set_limits(32'hFFFF_FFFF, 32'd1, 32'd1);
    send_point(32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'd0, 32'd0, 32'h0100_0000, 1'b1);
    // linear term dominates: score clamps at zero
    set_limits(32'd1, 32'hFFFF_FFFF, 32'd1);
    send_point(32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'd0, 1'b1);
    // exact 1.0 when nothing moves
    send_point(32'd7, 32'd7, 32'd7, 1'b0);
    send_point(32'd7, 32'd7, 32'd7, 1'b1);
  endtask

  task automatic test_random();
    int n;
    while (points_sent < 420) begin
      if ($urandom_range(0, 5) == 0) begin
        set_limits(($urandom_range(0, 9) == 0) ? 32'd0 : rnd_limit(),
                   ($urandom_range(0, 9) == 0) ? 32'd0 : rnd_limit(),
                   ($urandom_range(0, 9) == 0) ? 32'd0 : rnd_limit());
      end
      n = $urandom_range(1, 8);
      for (int i = 1; i <= n; i++)
        send_point(rnd_coord(), rnd_coord(), rnd_coord(), i == n);
    end
  endtask

  initial begin
    lin_max = '0;
    turn_max = '0;
    span = '0;
    last_x = '0;
    last_y = '0;
    last_h = '0;
    first_pt = 1'b1;
    len_acc = '0;
    turn_acc = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unset();
    test_single_point();
    test_extremes();
    test_score_bounds();
    test_random();
    wait_idle();
    $display("Covered %0d points in %0d trajectories, %0d results checked, %0d errors.",
             points_sent, trajs_sent, scores_seen, errors);
    if (errors == 0 && scores_due.size() == 0) $display("trajectory_speed_score test passed");
    else $display("trajectory_speed_score test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("trajectory_speed_score test failed");
    $finish;
  end

endmodule
